### design/rbac_pkg.sv
package rbac_pkg;

  localparam int NUM_SUBJECTS  = 16;
  localparam int NUM_RESOURCES = 64;
  localparam int SUB_IDX_W = (NUM_SUBJECTS > 1) ? $clog2(NUM_SUBJECTS) : 1;
  localparam int RES_IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [4:0] P_R = 5'd1;
  localparam logic [4:0] P_W = 5'd2;
  localparam logic [4:0] P_X = 5'd4;
  localparam logic [4:0] P_D = 5'd8;
  localparam logic [4:0] P_A = 5'd16;
  localparam logic [4:0] OWNER_PERMS = P_R | P_W | P_X | P_D;

  typedef enum logic [1:0] {
    CMD_ADD_SUBJ = 2'd0,
    CMD_ADD_RES  = 2'd1,
    CMD_CHECK    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    V_ALLOW      = 3'd0,
    V_NOT_FOUND  = 3'd1,
    V_DISABLED   = 3'd2,
    V_READ_UP    = 3'd3,
    V_WRITE_DOWN = 3'd4,
    V_LACKING    = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  // packed MSB first, so cmd lands in the low bits of tdata
  typedef struct packed {
    logic [4:0] req_perm;
    logic [4:0] acl_admin;
    logic [4:0] acl_manager;
    logic [4:0] acl_analyst;
    logic [4:0] acl_user;
    logic [3:0] owner_id;
    logic       disabled;
    logic [1:0] level;
    logic [3:0] role_mask;
    logic [5:0] resource_id;
    logic [3:0] subject_id;
    logic [1:0] cmd;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [4:0] eff_perm;
    logic [2:0] verdict;
    logic       allow;
  } out_item_t;

  typedef struct packed {
    logic [3:0] roles;
    logic [1:0] level;
    logic       disabled;
  } subj_t;

  typedef struct packed {
    logic [3:0]      owner;
    logic [1:0]      label;
    logic [3:0][4:0] acl;
  } res_t;

  typedef struct packed {
    logic accept;
    logic load_res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_check;
  } dp_status_t;

endpackage

### design/rbac_ctrl.sv
module rbac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rbac_pkg::dp_status_t status_i,
  output rbac_pkg::ctrl_cmd_t  cmd_o
);
  import rbac_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.load_res = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.is_check) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (can_load) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/rbac_dp.sv
module rbac_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [rbac_pkg::IN_DATA_W-1:0]       in_data_i,
  output logic [rbac_pkg::OUT_DATA_W-1:0]      out_data_o,
  input  rbac_pkg::ctrl_cmd_t                  cmd_i,
  output rbac_pkg::dp_status_t                 status_o
);
  import rbac_pkg::*;

  in_item_t item;
  logic [SUB_IDX_W-1:0] sidx;
  logic [RES_IDX_W-1:0] ridx;
  logic sid_ok, rid_ok, subj_we, res_we;
  subj_t subj_wr;
  res_t  res_wr;

  subj_t subj_mem [NUM_SUBJECTS];
  res_t  res_mem  [NUM_RESOURCES];
  logic [NUM_SUBJECTS-1:0]  subj_vld_q;
  logic [NUM_RESOURCES-1:0] res_vld_q;

  subj_t      subj_rd_q;
  res_t       res_rd_q;
  logic       found_q;
  logic [3:0] sid_q;
  logic [4:0] req_q;

  logic [3:0] er;
  logic [4:0] eff;
  verdict_e   verdict;
  out_item_t  res_d, out_q;

  assign item   = in_item_t'(in_data_i);
  assign sidx   = SUB_IDX_W'(item.subject_id);
  assign ridx   = RES_IDX_W'(item.resource_id);
  assign sid_ok = int'(item.subject_id) < NUM_SUBJECTS;
  assign rid_ok = int'(item.resource_id) < NUM_RESOURCES;

  assign status_o.is_check = cmd_e'(item.cmd) == CMD_CHECK;
  assign subj_we = cmd_i.accept && cmd_e'(item.cmd) == CMD_ADD_SUBJ && sid_ok;
  assign res_we  = cmd_i.accept && cmd_e'(item.cmd) == CMD_ADD_RES && rid_ok;

  assign subj_wr = '{roles: item.role_mask, level: item.level, disabled: item.disabled};
  assign res_wr  = '{owner: item.owner_id, label: item.level,
                     acl: {item.acl_admin, item.acl_manager, item.acl_analyst, item.acl_user}};

  always_ff @(posedge clk_i) begin
    if (subj_we) begin
      subj_mem[sidx] <= subj_wr;
    end
    if (cmd_i.accept) begin
      subj_rd_q <= subj_mem[sidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[ridx] <= res_wr;
    end
    if (cmd_i.accept) begin
      res_rd_q <= res_mem[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subj_vld_q <= '0;
      res_vld_q  <= '0;
    end else begin
      if (subj_we) begin
        subj_vld_q[sidx] <= 1'b1;
      end
      if (res_we) begin
        res_vld_q[ridx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      found_q <= sid_ok && rid_ok && subj_vld_q[sidx] && res_vld_q[ridx];
      sid_q   <= item.subject_id;
      req_q   <= item.req_perm;
    end
  end

  // role hierarchy: admin > manager > analyst > user
  assign er = {subj_rd_q.roles[3],
               |subj_rd_q.roles[3:2],
               |subj_rd_q.roles[3:1],
               |subj_rd_q.roles[3:0]};

  always_comb begin
    eff     = '0;
    verdict = V_ALLOW;
    priority if (!found_q) begin
      verdict = V_NOT_FOUND;
    end else if (subj_rd_q.disabled) begin
      verdict = V_DISABLED;
    end else if ((req_q & P_R) != '0 && subj_rd_q.level < res_rd_q.label) begin
      verdict = V_READ_UP;
    end else if ((req_q & P_W) != '0 && subj_rd_q.level > res_rd_q.label) begin
      verdict = V_WRITE_DOWN;
    end else begin
      if (res_rd_q.owner == sid_q) begin
        eff = OWNER_PERMS;
      end
      for (int k = 0; k < 4; k++) begin
        if (er[k]) begin
          eff = eff | res_rd_q.acl[k];
        end
      end
      verdict = ((eff & req_q) == req_q) ? V_ALLOW : V_LACKING;
    end
  end

  assign res_d = '{pad: '0, eff_perm: eff, verdict: verdict, allow: verdict == V_ALLOW};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_q <= res_d;
    end
  end

  assign out_data_o = out_q;

endmodule

### design/rbac_mac_access_checker_top.sv
// Add subject / add resource: beats are taken back to back, no result beat.
// Check: both tables are read into registers as the beat is accepted; input is
// held off in LOOKUP until the output register is free and loads the result.
// The output register holds a result while the next beat is accepted.
// rst_ni (async, active low) clears all table valid bits and the control state.
module rbac_mac_access_checker_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd, subject_id, resource_id, role_mask, level, disabled, owner_id,
  // acl_user, acl_analyst, acl_manager, acl_admin, req_perm
  input  logic [rbac_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // allow, verdict, eff_perm, zero pad
  output logic [rbac_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import rbac_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  rbac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  rbac_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status)
  );

endmodule

### design/rbac_chk.sv
module rbac_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [rbac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rbac_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import rbac_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  a_allow_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == V_ALLOW)))
    else $error("allow disagrees with verdict");

  a_early_deny_eff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:1] == V_NOT_FOUND ||
      m_axis_tdata[3:1] == V_DISABLED || m_axis_tdata[3:1] == V_READ_UP ||
      m_axis_tdata[3:1] == V_WRITE_DOWN) |-> m_axis_tdata[8:4] == 5'd0)
    else $error("nonzero eff_perm on early deny");

  a_check_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_CHECK
      |=> !s_axis_tready ##1 m_axis_tvalid)
    else $error("check beat produced no result");

endmodule

bind rbac_mac_access_checker_top rbac_chk u_rbac_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
